/* design/impg_pkg.sv */
package impg_pkg;

    // fixed-point formats
    localparam int FRAC_BITS = 16;
    localparam int PT_W      = FRAC_BITS + 4;
    localparam int COEF_W    = 17;
    localparam int OFS_W     = 18;
    localparam int PROD_W    = COEF_W + PT_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int SHIFT_W   = SUM_W - FRAC_BITS;
    localparam int PRE_W     = SHIFT_W + 1;

    // port field widths
    localparam int RAND_W  = 16;
    localparam int PPU_W   = 13;
    localparam int CFG_W   = 15;
    localparam int CIDX_W  = 2;
    localparam int PIX_W   = 14;
    localparam int MAP_W   = 2;
    localparam int TDATA_W = 32;

    // pixel scaling widths
    localparam int SCALE_W = PT_W + PPU_W + 1;
    localparam int SPIX_W  = 16;
    localparam int SUMP_W  = SPIX_W + 1;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [PT_W-1:0]  PT_MAX     = {1'b0, {(PT_W-1){1'b1}}};
    localparam logic signed [PT_W-1:0]  PT_MIN     = {1'b1, {(PT_W-1){1'b0}}};
    localparam logic [PIX_W-1:0]        PIX_MAX    = {PIX_W{1'b1}};

    // map thresholds: map chosen by rand_value < threshold
    localparam logic [RAND_W-1:0] THR_STEM  = 16'd6554;
    localparam logic [RAND_W-1:0] THR_LEFT  = 16'd29492;
    localparam logic [RAND_W-1:0] THR_RIGHT = 16'd52429;

    // configuration reset values
    localparam logic [PPU_W-1:0] PPU_RESET    = 13'd1000;
    localparam logic [CFG_W-1:0] OFFSET_RESET = 15'd3500;
    localparam logic [CFG_W-1:0] SIZE_RESET   = 15'd7000;

    typedef enum logic [MAP_W-1:0] {
        MAP_STEM  = 2'd0,
        MAP_LEFT  = 2'd1,
        MAP_RIGHT = 2'd2,
        MAP_TOP   = 2'd3
    } map_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_PIXELS_PER_UNIT = 2'd0,
        CFG_ORIGIN_OFFSET   = 2'd1,
        CFG_IMAGE_WIDTH     = 2'd2,
        CFG_IMAGE_HEIGHT    = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        ENG_IDLE = 1'b0,
        ENG_ACC  = 1'b1
    } eng_state_t;

    // affine map coefficients: x' = a*x + b*y + e, y' = c*x + d*y + f
    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] d;
        logic signed [OFS_W-1:0]  e;
        logic signed [OFS_W-1:0]  f;
    } coef_t;

    // new point handed from engine to raster stage
    typedef struct packed {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        map_t                   map;
    } coord_t;

    // coefficients rounded to 16 fraction bits
    function automatic coef_t map_coef(input map_t m);
        coef_t k;
        case (m)
            MAP_STEM:
            begin
                k.a = 17'sd9175;   k.b = 17'sd655;     k.e = -18'sd5243;
                k.c = 17'sd0;      k.d = 17'sd33423;   k.f = -18'sd85852;
            end
            MAP_LEFT:
            begin
                k.a = 17'sd28180;  k.b = 17'sd34079;   k.e = 18'sd97649;
                k.c = -17'sd29491; k.d = 17'sd32768;   k.f = -18'sd49152;
            end
            MAP_RIGHT:
            begin
                k.a = 17'sd29491;  k.b = -17'sd32113;  k.e = -18'sd106168;
                k.c = 17'sd30802;  k.d = 17'sd30802;   k.f = -18'sd48497;
            end
            MAP_TOP:
            begin
                k.a = 17'sd32113;  k.b = 17'sd0;       k.e = 18'sd1311;
                k.c = 17'sd0;      k.d = 17'sd33423;   k.f = 18'sd106168;
            end
            default:
            begin
                k = '0;
            end
        endcase
        return k;
    endfunction

endpackage

/* design/impg_front.sv */
module impg_front
    import impg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [RAND_W-1:0] rand_value,
    output logic              q_valid,
    output map_t              q_map,
    input  logic              q_pop
);

    map_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;
    map_t       map_sel;

    // pick the map from the random fraction
    always_comb
    begin
        if (rand_value < THR_STEM)
            map_sel = MAP_STEM;
        else if (rand_value < THR_LEFT)
            map_sel = MAP_LEFT;
        else if (rand_value < THR_RIGHT)
            map_sel = MAP_RIGHT;
        else
            map_sel = MAP_TOP;
    end

    // two-entry queue toward the engine
    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_map    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= map_sel;
    end

endmodule

/* design/impg_engine.sv */
module impg_engine
    import impg_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   q_valid,
    input  map_t   q_map,
    output logic   q_pop,
    output logic   coord_valid,
    input  logic   coord_ready,
    output coord_t coord
);

    eng_state_t state_reg, state_next;

    logic signed [PT_W-1:0]   point_x_reg, point_y_reg;
    logic signed [PROD_W-1:0] prod_xa_reg, prod_xb_reg, prod_yc_reg, prod_yd_reg;
    map_t                     map_reg;
    coef_t                    k_mul, k_acc;
    logic                     start;
    logic                     finish;
    logic signed [SUM_W-1:0]  sum_x, sum_y;
    logic signed [SHIFT_W-1:0] sh_x, sh_y;
    logic signed [PRE_W-1:0]  pre_x, pre_y;
    logic signed [PT_W-1:0]   new_x, new_y;

    function automatic logic signed [PT_W-1:0] sat_point(input logic signed [PRE_W-1:0] v);
        logic signed [PT_W-1:0] r;
        if (v > PRE_W'(PT_MAX))
            r = PT_MAX;
        else if (v < PRE_W'(PT_MIN))
            r = PT_MIN;
        else
            r = v[PT_W-1:0];
        return r;
    endfunction

    // next state
    always_comb
    begin
        case (state_reg)
            ENG_IDLE: state_next = q_valid ? ENG_ACC : ENG_IDLE;
            ENG_ACC:  state_next = coord_ready ? ENG_IDLE : ENG_ACC;
            default:  state_next = ENG_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop       = 1'b0;
        coord_valid = 1'b0;
        case (state_reg)
            ENG_IDLE: q_pop = q_valid;
            ENG_ACC:  coord_valid = 1'b1;
            default:
            begin
                q_pop       = 1'b0;
                coord_valid = 1'b0;
            end
        endcase
    end

    assign start  = q_pop;
    assign finish = coord_valid && coord_ready;
    assign k_mul  = map_coef(q_map);
    assign k_acc  = map_coef(map_reg);

    // sum products, round, floor shift, add offset, saturate
    always_comb
    begin
        sum_x = SUM_W'(prod_xa_reg) + SUM_W'(prod_xb_reg) + ROUND_HALF;
        sum_y = SUM_W'(prod_yc_reg) + SUM_W'(prod_yd_reg) + ROUND_HALF;
        sh_x  = sum_x[SUM_W-1:FRAC_BITS];
        sh_y  = sum_y[SUM_W-1:FRAC_BITS];
        pre_x = PRE_W'(sh_x) + PRE_W'(k_acc.e);
        pre_y = PRE_W'(sh_y) + PRE_W'(k_acc.f);
        new_x = sat_point(pre_x);
        new_y = sat_point(pre_y);
    end

    assign coord.x   = new_x;
    assign coord.y   = new_y;
    assign coord.map = map_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ENG_IDLE;
            point_x_reg <= '0;
            point_y_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                point_x_reg <= new_x;
                point_y_reg <= new_y;
            end
        end
    end

    // products of the stored point, one multiply per term
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_xa_reg <= k_mul.a * point_x_reg;
            prod_xb_reg <= k_mul.b * point_y_reg;
            prod_yc_reg <= k_mul.c * point_x_reg;
            prod_yd_reg <= k_mul.d * point_y_reg;
            map_reg     <= q_map;
        end
    end

endmodule

/* design/impg_raster.sv */
module impg_raster
    import impg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               coord_valid,
    output logic               coord_ready,
    input  coord_t             coord,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [TDATA_W-1:0] out_data
);

    logic [PPU_W-1:0] ppu_reg;
    logic [CFG_W-1:0] offset_reg, width_reg, height_reg;

    logic   c_valid_reg, p_valid_reg, o_valid_reg;
    coord_t c_reg;
    logic signed [SCALE_W-1:0] p_x_reg, p_y_reg;
    map_t   p_map_reg, o_map_reg;
    logic [PIX_W-1:0] o_row_reg, o_col_reg;

    logic o_free, p_move, p_free, c_move, c_load;
    logic signed [PPU_W:0] ppu_s;
    logic [SPIX_W-1:0] pix_x, pix_y;
    logic [SUMP_W-1:0] col_sum, row_sum;
    logic [CFG_W-1:0]  width_m1, height_m1, row_diff;
    logic [PIX_W-1:0]  w_bound, h_bound, col_val, row_val;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppu_reg    <= PPU_RESET;
            offset_reg <= OFFSET_RESET;
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_PIXELS_PER_UNIT: ppu_reg    <= cfg_data[PPU_W-1:0];
                CFG_ORIGIN_OFFSET:   offset_reg <= cfg_data;
                CFG_IMAGE_WIDTH:     width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT:    height_reg <= cfg_data;
                default:             ppu_reg    <= ppu_reg;
            endcase
        end
    end

    // stage advance with back pressure from the output
    assign o_free      = !o_valid_reg || out_ready;
    assign p_move      = p_valid_reg && o_free;
    assign p_free      = !p_valid_reg || p_move;
    assign c_move      = c_valid_reg && p_free;
    assign coord_ready = !c_valid_reg || c_move;
    assign c_load      = coord_valid && coord_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (coord_ready)
                c_valid_reg <= coord_valid;
            if (p_free)
                p_valid_reg <= c_valid_reg;
            if (o_free)
                o_valid_reg <= p_valid_reg;
        end
    end

    // scale by pixels per unit
    assign ppu_s = $signed({1'b0, ppu_reg});

    always_ff @(posedge clk)
    begin
        if (c_load)
            c_reg <= coord;
        if (c_move)
        begin
            p_x_reg   <= c_reg.x * ppu_s;
            p_y_reg   <= c_reg.y * ppu_s;
            p_map_reg <= c_reg.map;
        end
        if (p_move)
        begin
            o_row_reg <= row_val;
            o_col_reg <= col_val;
            o_map_reg <= p_map_reg;
        end
    end

    // integer pixels, offset, clamp and row flip
    always_comb
    begin
        pix_x = (p_x_reg <= 0) ? '0 : p_x_reg[FRAC_BITS+SPIX_W-1:FRAC_BITS];
        pix_y = (p_y_reg <= 0) ? '0 : p_y_reg[FRAC_BITS+SPIX_W-1:FRAC_BITS];
        col_sum = SUMP_W'(pix_x) + SUMP_W'(offset_reg);
        row_sum = SUMP_W'(pix_y) + SUMP_W'(offset_reg);

        width_m1  = (width_reg == '0) ? '0 : width_reg - 1'b1;
        height_m1 = (height_reg == '0) ? '0 : height_reg - 1'b1;
        w_bound   = (width_m1 > CFG_W'(PIX_MAX)) ? PIX_MAX : width_m1[PIX_W-1:0];
        h_bound   = (height_m1 > CFG_W'(PIX_MAX)) ? PIX_MAX : height_m1[PIX_W-1:0];

        col_val = (col_sum > SUMP_W'(w_bound)) ? w_bound : col_sum[PIX_W-1:0];

        row_diff = height_m1 - row_sum[CFG_W-1:0];
        if (row_sum >= SUMP_W'(height_reg))
            row_val = h_bound;
        else if (row_diff > CFG_W'(h_bound))
            row_val = h_bound;
        else
            row_val = row_diff[PIX_W-1:0];
    end

    assign out_valid = o_valid_reg;
    assign out_data  = {{(TDATA_W-2*PIX_W-MAP_W){1'b0}}, o_map_reg, o_col_reg, o_row_reg};

endmodule

/* design/ifs_maple_point_generator_unit.sv */
// channel     | direction | handshake                    | payload
// ------------+-----------+------------------------------+-----------------------------------
// s_axis      | in        | s_axis_tvalid/s_axis_tready  | tdata[15:0] rand_value
// m_axis      | out       | m_axis_tvalid/m_axis_tready  | tdata row[13:0] col[27:14] map[29:28]
// cfg         | in        | cfg_valid/cfg_ready          | cfg_index register, cfg_data value
//
// the point recurrence finishes one item before taking the next: four coefficient multiplies into
// registers, then sum, round, offset and saturate back into the point registers
// a two-entry queue after the input lets the front keep taking items while the
// engine or the output stalls; pixel scaling trails in three more stages
// reset returns the point to the origin and the registers to their defaults

module ifs_maple_point_generator_unit
    import impg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [RAND_W-1:0]  s_axis_tdata,   // rand_value[15:0]
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // pixel_row[13:0], pixel_col[27:14], map_index[29:28]
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    logic   q_valid;
    map_t   q_map;
    logic   q_pop;
    logic   coord_valid;
    logic   coord_ready;
    coord_t coord;

    assign cfg_ready = 1'b1;

    // input acceptance and map selection
    impg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .rand_value (s_axis_tdata),
        .q_valid    (q_valid),
        .q_map      (q_map),
        .q_pop      (q_pop)
    );

    // affine map recurrence
    impg_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_map       (q_map),
        .q_pop       (q_pop),
        .coord_valid (coord_valid),
        .coord_ready (coord_ready),
        .coord       (coord)
    );

    // pixel scaling, clamp and output register
    impg_raster u_raster (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .coord_valid (coord_valid),
        .coord_ready (coord_ready),
        .coord       (coord),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata)
    );

endmodule

/* design/impg_checker.sv */
module impg_checker
    import impg_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic [RAND_W-1:0]  s_axis_tdata,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [CIDX_W-1:0]  cfg_index,
    input logic [CFG_W-1:0]   cfg_data
);

    logic [2:0]       pending_reg;
    logic [CFG_W-1:0] width_reg, height_reg;
    logic             in_xact, out_xact;

    assign in_xact  = s_axis_tvalid && s_axis_tready;
    assign out_xact = m_axis_tvalid && m_axis_tready;

    // items in flight and the image size last written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 3'd0;
            width_reg   <= SIZE_RESET;
            height_reg  <= SIZE_RESET;
        end
        else
        begin
            pending_reg <= pending_reg + 3'(in_xact) - 3'(out_xact);
            if (cfg_valid && cfg_ready && cfg_index == CFG_IMAGE_WIDTH)
                width_reg <= cfg_data;
            if (cfg_valid && cfg_ready && cfg_index == CFG_IMAGE_HEIGHT)
                height_reg <= cfg_data;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // no result without an item in flight
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 3'd0)
        else $error("result without an accepted item");

    // a full pipeline stops taking items
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 3'd6 |-> !s_axis_tready)
        else $error("item taken with pipeline full");

    // column inside the image
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && width_reg != '0 |-> CFG_W'(m_axis_tdata[2*PIX_W-1:PIX_W]) < width_reg)
        else $error("column outside image");

    // row inside the image
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && height_reg != '0 |-> CFG_W'(m_axis_tdata[PIX_W-1:0]) < height_reg)
        else $error("row outside image");

endmodule

bind ifs_maple_point_generator_unit impg_checker u_impg_checker (.*);

/* verif/tb_ifs_maple_point_generator_unit.sv */
`timescale 1ns / 100ps

module tb_ifs_maple_point_generator_unit;
    import impg_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    localparam int SETTLE       = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 200;
    localparam int PT_LIMIT     = 524288;

    // one painted pixel as the block reports it
    typedef struct {
        logic [PIX_W-1:0] row;
        logic [PIX_W-1:0] col;
        map_t             map;
    } pixel_t;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [RAND_W-1:0]  s_axis_tdata;    // rand_value[15:0]
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;    // pixel_row[13:0], pixel_col[27:14], map_index[29:28]
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    // affine maps in hundredths: a, b, c, d, e, f
    int leaf_hundredths [4][6] = '{
        '{ 14,   1,   0,  51,   -8, -131 },
        '{ 43,  52, -45,  50,  149,  -75 },
        '{ 45, -49,  47,  47, -162,  -74 },
        '{ 49,   0,   0,  51,    2,  162 }
    };

    // band edges of the map selector
    int unsigned band_edges [3] = '{ 6554, 29492, 52429 };

    // mirror of the block state and registers
    longint leaf_x;
    longint leaf_y;
    longint scale_ppu;
    longint scale_offset;
    longint raster_width;
    longint raster_height;

    pixel_t expected_pixels [$];
    int     error_count = 0;
    int     cycle_count = 0;
    int     send_idle_pct;
    int     recv_stall_pct;

    ifs_maple_point_generator_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    // coefficient in hundredths to 16 fraction bits, ties away from zero
    function automatic longint quantize(input int hundredths);
        longint scaled;
        scaled = longint'(hundredths) * 65536;
        if (scaled >= 0)
            return (scaled + 50) / 100;
        return -((-scaled + 50) / 100);
    endfunction

    // one coordinate of the affine map, rounded and saturated to q4.16
    function automatic longint affine_coord(input map_t m, input int first);
        longint acc;
        longint v;
        acc = quantize(leaf_hundredths[int'(m)][first]) * leaf_x
            + quantize(leaf_hundredths[int'(m)][first + 1]) * leaf_y
            + (longint'(1) <<< (FRAC_BITS - 1));
        v = (acc >>> FRAC_BITS) + quantize(leaf_hundredths[int'(m)][4 + first / 2]);
        if (v > PT_LIMIT - 1)
            v = PT_LIMIT - 1;
        if (v < -PT_LIMIT)
            v = -PT_LIMIT;
        return v;
    endfunction

    // coordinate to whole pixels, non-positive gives zero
    function automatic longint to_pixel_units(input longint coord);
        longint p;
        p = coord * scale_ppu;
        if (p <= 0)
            return 0;
        return p >>> FRAC_BITS;
    endfunction

    function automatic longint last_index(input longint extent);
        longint b;
        b = (extent == 0) ? 0 : extent - 1;
        return (b > 16383) ? 16383 : b;
    endfunction

    // advance the point and work out the pixel it paints
    function automatic pixel_t paint_pixel(input logic [RAND_W-1:0] r);
        int unsigned rv;
        map_t        m;
        longint      nx;
        longint      ny;
        longint      col;
        longint      row;
        longint      sy;
        pixel_t      p;
        rv = r;
        if (rv * 10 < 65536)
            m = MAP_STEM;
        else if (rv * 100 < 45 * 65536)
            m = MAP_LEFT;
        else if (rv * 10 < 8 * 65536)
            m = MAP_RIGHT;
        else
            m = MAP_TOP;
        nx = affine_coord(m, 0);
        ny = affine_coord(m, 2);
        leaf_x = nx;
        leaf_y = ny;
        col = to_pixel_units(nx) + scale_offset;
        if (col > last_index(raster_width))
            col = last_index(raster_width);
        sy = to_pixel_units(ny) + scale_offset;
        if (sy >= raster_height)
            row = last_index(raster_height);
        else
        begin
            row = raster_height - 1 - sy;
            if (row > last_index(raster_height))
                row = last_index(raster_height);
        end
        p.row = PIX_W'(row);
        p.col = PIX_W'(col);
        p.map = m;
        return p;
    endfunction

    // compare one output transaction with the oldest expected pixel
    task automatic check_pixel(input logic [TDATA_W-1:0] d);
        pixel_t exp_pix;
        logic [PIX_W-1:0] got_row;
        logic [PIX_W-1:0] got_col;
        logic [MAP_W-1:0] got_map;
        got_row = d[PIX_W-1:0];
        got_col = d[2*PIX_W-1:PIX_W];
        got_map = d[2*PIX_W+MAP_W-1:2*PIX_W];
        if (expected_pixels.size() == 0)
        begin
            $display("%0t: unexpected pixel, expected none actual row %0d col %0d map %0d",
                     $time, got_row, got_col, got_map);
            error_count++;
        end
        else
        begin
            exp_pix = expected_pixels.pop_front();
            if (got_row !== exp_pix.row)
            begin
                $display("%0t: pixel_row expected %0d actual %0d", $time, exp_pix.row, got_row);
                error_count++;
            end
            if (got_col !== exp_pix.col)
            begin
                $display("%0t: pixel_col expected %0d actual %0d", $time, exp_pix.col, got_col);
                error_count++;
            end
            if (got_map !== exp_pix.map)
            begin
                $display("%0t: map_index expected %0d actual %0d", $time, exp_pix.map, got_map);
                error_count++;
            end
        end
    endtask

    // output side: random stalls and result checking
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_pixel(m_axis_tdata);
        m_axis_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one random fraction into the block, valid stays high after the transaction
    task automatic send_rand(input logic [RAND_W-1:0] r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_pixels.push_back(paint_pixel(r));
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_PIXELS_PER_UNIT: scale_ppu     = value[PPU_W-1:0];
            CFG_ORIGIN_OFFSET:   scale_offset  = value;
            CFG_IMAGE_WIDTH:     raster_width  = value;
            CFG_IMAGE_HEIGHT:    raster_height = value;
            default:             ;
        endcase
    endtask

    // program all four registers once the block has gone idle
    task automatic set_raster(input longint ppu, input longint offset,
                              input longint width, input longint height);
        wait_drained();
        write_reg(CFG_PIXELS_PER_UNIT, CFG_W'(ppu));
        write_reg(CFG_ORIGIN_OFFSET, CFG_W'(offset));
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(width));
        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(height));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // band edges of the map selector under the reset raster
    task automatic test_map_bands();
        logic [RAND_W-1:0] picks [10];
        picks = '{ 16'd0, 16'd6553, 16'd6554, 16'd29491, 16'd29492,
                   16'd52428, 16'd52429, 16'd65535, 16'd65535, 16'd0 };
        foreach (picks[i])
            send_rand(picks[i]);
        end_burst();
        wait_drained();
    endtask

    // largest, smallest, zero and oversized raster settings
    task automatic test_raster_extremes();
        set_raster(4096, 16384, 16384, 16384);
        send_rand(16'd60000);
        send_rand(16'd20000);
        send_rand(16'd40000);
        send_rand(16'd1000);
        end_burst();
        set_raster(1, 0, 1, 1);
        send_rand(16'd65535);
        send_rand(16'd30000);
        send_rand(16'd10000);
        end_burst();
        set_raster(2000, 0, 0, 0);
        send_rand(16'd50000);
        send_rand(16'd3000);
        send_rand(16'd55000);
        end_burst();
        wait_drained();
    endtask

    // long random runs under each flow-control mix
    task automatic test_random_traffic();
        int idle_mix [4];
        int stall_mix [4];
        longint ppu;
        longint offset;
        int unsigned edge_pick;
        logic [RAND_W-1:0] r;
        idle_mix  = '{ 0, 69,  0, 30 };
        stall_mix = '{ 0,  0, 69, 30 };
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_drained();
            if (phase % 2 == 0)
            begin
                // leaf centered and mostly inside the image
                ppu    = $urandom_range(50, 2000);
                offset = ppu * 7 / 2;
                set_raster(ppu, offset, 2 * offset + $urandom_range(0, 50),
                           2 * offset + $urandom_range(0, 50));
            end
            else
                set_raster($urandom_range(1, 4096), $urandom_range(0, 16384),
                           $urandom_range(1, 16384), $urandom_range(1, 16384));
            send_idle_pct  = idle_mix[phase];
            recv_stall_pct = stall_mix[phase];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(7) == 0)
                begin
                    edge_pick = band_edges[$urandom_range(2)];
                    r = RAND_W'(edge_pick - 2 + $urandom_range(0, 3));
                end
                else
                    r = RAND_W'($urandom);
                send_rand(r);
            end
            end_burst();
        end
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // reset and test sequence
    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_PIXELS_PER_UNIT;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        leaf_x         = 0;
        leaf_y         = 0;
        scale_ppu      = 1000;
        scale_offset   = 3500;
        raster_width   = 7000;
        raster_height  = 7000;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_map_bands();
        test_raster_extremes();
        test_random_traffic();

        if (error_count == 0 && expected_pixels.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* ifs_maple_point_generator_unit.f */
design/impg_pkg.sv
design/impg_front.sv
design/impg_engine.sv
design/impg_raster.sv
design/ifs_maple_point_generator_unit.sv
design/impg_checker.sv
verif/tb_ifs_maple_point_generator_unit.sv
